>>> rtl/core/svpwm_pkg.sv
`timescale 1ns / 1ps

package svpwm_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SIXTH_UNITS = 393216;
    localparam int SINE_ENTRIES = (65536 * SINE_TABLE_DEPTH) / SIXTH_UNITS + 1;
    localparam int SIN_IDX_W = $clog2(SINE_ENTRIES);

    localparam int IDX_Q_W = $clog2(SINE_TABLE_DEPTH) + 1;
    localparam int IDX_SCALE_W = 17 + IDX_Q_W;
    localparam int IDX_DIV3_SHIFT = IDX_Q_W + 1;
    localparam int IDX_PROD_W = IDX_Q_W + IDX_DIV3_SHIFT;
    localparam logic [IDX_DIV3_SHIFT-1:0] IDX_DIV3_MULT =
        IDX_DIV3_SHIFT'(((2 ** IDX_DIV3_SHIFT) + 2) / 3);

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;

    localparam int T_Q_W = 22;
    localparam int T_DIV3_SHIFT = 23;
    localparam logic [T_Q_W-1:0] T_DIV3_MULT = 22'd2796203;

    localparam int T_W = 22;
    localparam int D_W = 26;
    localparam int N_W = 28;
    localparam int LIMIT_W = 23;
    localparam int NUM_W = LIMIT_W + 16;
    localparam int DIV_STEPS = 16;
    localparam int FRONT_STAGES = 10;
    localparam int LATENCY = FRONT_STAGES + DIV_STEPS;

    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_VOLTAGE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD = 4'd1;
    localparam logic [15:0] SUPPLY_VOLTAGE_RESET = 16'd3072;
    localparam logic [15:0] PWM_PERIOD_RESET = 16'd4199;

    localparam logic [1:0] USE_T1 = 2'b01;
    localparam logic [1:0] USE_T2 = 2'b10;

    typedef struct packed {
        logic signed [15:0] voltage_q;
        logic [15:0] electrical_angle;
    } cmd_t;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
    } result_t;

    typedef struct packed {
        logic zero;
        logic [2:0][NUM_W-1:0] num;
    } div_req_t;

    typedef logic [SINE_ENTRIES-1:0][15:0] sine_table_t;

    function automatic sine_table_t build_sine_table();
        sine_table_t tab;
        logic [63:0] theta;
        logic [63:0] x;
        logic [63:0] p;
        tab = '0;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            theta = (64'(k) * TWO_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            x = (theta * theta) >> 30;
            p = Q30_ONE - x / 64'd42;
            p = Q30_ONE - ((x * p) >> 30) / 64'd20;
            p = Q30_ONE - ((x * p) >> 30) / 64'd6;
            tab[k] = 16'(((theta * p) >> 30) >> 14);
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    function automatic logic [SIN_IDX_W-1:0] sine_index(input logic [16:0] offset);
        logic [IDX_SCALE_W-1:0] scaled;
        logic [IDX_Q_W-1:0] q;
        logic [IDX_PROD_W-1:0] prod;
        scaled = IDX_SCALE_W'(offset) * IDX_SCALE_W'(SINE_TABLE_DEPTH);
        q = IDX_Q_W'(scaled >> 17);
        prod = IDX_PROD_W'(q) * IDX_PROD_W'(IDX_DIV3_MULT);
        return SIN_IDX_W'(prod >> IDX_DIV3_SHIFT);
    endfunction

    function automatic logic [1:0] phase_mix(input logic [2:0] sector, input logic [1:0] phase);
        logic [2:0][1:0] row;
        case (sector)
            3'd0: row = {2'b00, USE_T2, USE_T1 | USE_T2};
            3'd1: row = {2'b00, USE_T1 | USE_T2, USE_T1};
            3'd2: row = {USE_T2, USE_T1 | USE_T2, 2'b00};
            3'd3: row = {USE_T1 | USE_T2, USE_T1, 2'b00};
            3'd4: row = {USE_T1 | USE_T2, 2'b00, USE_T2};
            3'd5: row = {USE_T1, 2'b00, USE_T1 | USE_T2};
            default: row = '0;
        endcase
        return (phase < 2'd3) ? row[phase] : 2'b00;
    endfunction

endpackage

>>> rtl/core/space_vector_pwm_compare.sv
`timescale 1ns / 1ps

// Space-vector PWM compare generator. A command transaction carries a signed
// Q8.8 quadrature voltage and a 16-bit electrical angle. It is taken at a
// rising edge where start is high and busy is low; busy is only high in the
// cycle right after reset, so one command can be taken in every cycle.
// Each command yields exactly one result transaction: done is high for one
// cycle while result holds the three phase compare values, each at most
// pwm_period. The receiver cannot stall the block, so results are never held.
// The front end has ten stages of angle, sine lookup, active time and phase
// arithmetic, followed by a 16-stage divider pipeline that produces one
// quotient bit per stage.
// Throughput is one command per cycle.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes supply_voltage at index 0 and pwm_period at index 1; other indexes
// are ignored. The user must write configuration only while no command is
// in flight; the block itself does not enforce it. Reset empties the
// pipeline and restores supply_voltage to 12 V and pwm_period to 4199.

module space_vector_pwm_compare (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  svpwm_pkg::cmd_t cmd,
    output logic done,
    output svpwm_pkg::result_t result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [svpwm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import svpwm_pkg::*;

    logic busy_reg;
    logic [15:0] supply_voltage_reg;
    logic [15:0] pwm_period_reg;
    logic [FRONT_STAGES-1:0] vld_reg;
    logic accept;
    logic [LIMIT_W-1:0] limit;

    logic [15:0] angle;
    logic [18:0] angle6;
    logic [2:0] sector;
    logic [18:0] e1_full;

    logic [2:0] s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    logic [16:0] e1_reg;
    logic [15:0] e2_reg;
    logic signed [15:0] vq1_reg, vq2_reg, vq3_reg, vq4_reg;
    logic [SIN_IDX_W-1:0] k1_reg, k2_reg;
    logic [15:0] sin1_reg, sin2_reg;
    logic [16:0] kk1_reg, kk2_reg;
    logic [32:0] kk1_prod, kk2_prod;
    logic signed [33:0] prod1_reg, prod2_reg;
    logic [33:0] mag1, mag2;
    logic neg1_reg, neg2_reg;
    logic [T_Q_W-1:0] q1_reg, q2_reg;
    logic [2*T_Q_W-1:0] r1_prod, r2_prod;
    logic [20:0] tm1, tm2;
    logic signed [T_W-1:0] t1_reg, t2_reg;
    logic signed [D_W-1:0] d_next [3];
    logic signed [D_W-1:0] d_reg [3];
    logic [LIMIT_W-1:0] v_next [3];
    logic [LIMIT_W-1:0] v_reg [3];
    logic zero9_reg;
    logic zero10_reg;
    div_req_t num_next;
    logic [2:0][NUM_W-1:0] num_reg;
    div_req_t div_req;

    assign accept = start && !busy_reg;
    assign busy = busy_reg;
    assign cfg_ready = 1'b1;
    assign limit = {supply_voltage_reg, 7'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            supply_voltage_reg <= SUPPLY_VOLTAGE_RESET;
            pwm_period_reg <= PWM_PERIOD_RESET;
            vld_reg <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], accept};
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SUPPLY_VOLTAGE: supply_voltage_reg <= cfg_data;
                    REG_PWM_PERIOD: pwm_period_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        angle = cmd.electrical_angle + 16'd16384;
        angle6 = {1'b0, angle, 2'b00} + {2'b00, angle, 1'b0};
        sector = angle6[18:16];
        e1_full = (19'(sector + 3'd1) << 16) - angle6;
    end

    always_comb
    begin
        kk1_prod = 33'(SQRT3_Q16) * 33'(sin1_reg);
        kk2_prod = 33'(SQRT3_Q16) * 33'(sin2_reg);
        mag1 = prod1_reg[33] ? 34'(-prod1_reg) : 34'(prod1_reg);
        mag2 = prod2_reg[33] ? 34'(-prod2_reg) : 34'(prod2_reg);
        r1_prod = (2*T_Q_W)'(q1_reg) * (2*T_Q_W)'(T_DIV3_MULT);
        r2_prod = (2*T_Q_W)'(q2_reg) * (2*T_Q_W)'(T_DIV3_MULT);
        tm1 = 21'(r1_prod >> T_DIV3_SHIFT);
        tm2 = 21'(r2_prod >> T_DIV3_SHIFT);
    end

    always_comb
    begin
        logic signed [D_W-1:0] t1x;
        logic signed [D_W-1:0] t2x;
        logic signed [D_W-1:0] t0x;
        logic signed [D_W-1:0] sum;
        logic [1:0] mix;
        t1x = D_W'(t1_reg);
        t2x = D_W'(t2_reg);
        t0x = D_W'(65536) - t1x - t2x;
        for (int ph = 0; ph < 3; ph++)
        begin
            mix = phase_mix(s7_reg, 2'(ph));
            sum = '0;
            if ((mix & USE_T1) != 2'b00)
            begin
                sum = sum + t1x;
            end
            if ((mix & USE_T2) != 2'b00)
            begin
                sum = sum + t2x;
            end
            d_next[ph] = (sum <<< 1) + t0x;
        end
    end

    always_comb
    begin
        logic signed [N_W-1:0] n;
        logic signed [N_W-1:0] lim_s;
        lim_s = $signed(N_W'(limit));
        for (int ph = 0; ph < 3; ph++)
        begin
            n = (N_W'(d_reg[ph]) <<< 1) + N_W'(d_reg[ph]);
            if (n <= 0)
            begin
                v_next[ph] = '0;
            end
            else if (n > lim_s)
            begin
                v_next[ph] = limit;
            end
            else
            begin
                v_next[ph] = LIMIT_W'(n);
            end
        end
    end

    always_comb
    begin
        num_next.zero = zero9_reg;
        for (int ph = 0; ph < 3; ph++)
        begin
            num_next.num[ph] = NUM_W'(v_reg[ph]) * NUM_W'(pwm_period_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= sector;
        e1_reg <= e1_full[16:0];
        e2_reg <= angle6[15:0];
        vq1_reg <= cmd.voltage_q;

        s2_reg <= s1_reg;
        k1_reg <= sine_index(e1_reg);
        k2_reg <= sine_index({1'b0, e2_reg});
        vq2_reg <= vq1_reg;

        s3_reg <= s2_reg;
        sin1_reg <= SINE_TABLE[k1_reg];
        sin2_reg <= SINE_TABLE[k2_reg];
        vq3_reg <= vq2_reg;

        s4_reg <= s3_reg;
        kk1_reg <= kk1_prod[32:16];
        kk2_reg <= kk2_prod[32:16];
        vq4_reg <= vq3_reg;

        s5_reg <= s4_reg;
        prod1_reg <= 34'($signed({1'b0, kk1_reg})) * 34'(vq4_reg);
        prod2_reg <= 34'($signed({1'b0, kk2_reg})) * 34'(vq4_reg);

        s6_reg <= s5_reg;
        neg1_reg <= prod1_reg[33];
        neg2_reg <= prod2_reg[33];
        q1_reg <= mag1[31:10];
        q2_reg <= mag2[31:10];

        s7_reg <= s6_reg;
        t1_reg <= neg1_reg ? -$signed({1'b0, tm1}) : $signed({1'b0, tm1});
        t2_reg <= neg2_reg ? -$signed({1'b0, tm2}) : $signed({1'b0, tm2});

        d_reg <= d_next;

        v_reg <= v_next;
        zero9_reg <= (supply_voltage_reg == 16'd0);

        num_reg <= num_next.num;
        zero10_reg <= num_next.zero;
    end

    assign div_req.zero = zero10_reg;
    assign div_req.num = num_reg;

    svpwm_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(vld_reg[FRONT_STAGES-1]),
        .req(div_req),
        .limit(limit),
        .out_valid(done),
        .quot(result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("Result transaction without a matching command.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("Command transaction produced no result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (s1_reg < 3'd6))
        else $error("Sector index out of range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] |-> (t1_reg <= 22'sd1048576 && t1_reg >= -22'sd1048576
                        && t2_reg <= 22'sd1048576 && t2_reg >= -22'sd1048576))
        else $error("Active time exceeds its bound.");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[8] |-> (v_reg[0] <= {$past(supply_voltage_reg), 7'd0}
                        && v_reg[1] <= {$past(supply_voltage_reg), 7'd0}
                        && v_reg[2] <= {$past(supply_voltage_reg), 7'd0}))
        else $error("Clamped phase voltage exceeds the supply.");

endmodule

>>> rtl/core/svpwm_div.sv
`timescale 1ns / 1ps

module svpwm_div (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  svpwm_pkg::div_req_t req,
    input  logic [svpwm_pkg::LIMIT_W-1:0] limit,
    output logic out_valid,
    output svpwm_pkg::result_t quot
);
    import svpwm_pkg::*;

    logic [DIV_STEPS-1:0] valid_reg;
    logic [DIV_STEPS-1:0] valid_next;
    logic [DIV_STEPS-1:0] zero_reg;
    logic [DIV_STEPS-1:0] zero_next;
    logic [LIMIT_W-1:0] rem_reg [DIV_STEPS][3];
    logic [LIMIT_W-1:0] rem_next [DIV_STEPS][3];
    logic [15:0] low_reg [DIV_STEPS][3];
    logic [15:0] low_next [DIV_STEPS][3];
    logic [15:0] quot_reg [DIV_STEPS][3];
    logic [15:0] quot_next [DIV_STEPS][3];

    always_comb
    begin
        logic [LIMIT_W-1:0] rin;
        logic [15:0] lin;
        logic [15:0] qin;
        logic [LIMIT_W:0] trial;
        logic ge;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            valid_next[j] = (j == 0) ? in_valid : valid_reg[(j == 0) ? 0 : j - 1];
            zero_next[j] = (j == 0) ? req.zero : zero_reg[(j == 0) ? 0 : j - 1];
            for (int p = 0; p < 3; p++)
            begin
                if (j == 0)
                begin
                    rin = req.num[p][NUM_W-1:16];
                    lin = req.num[p][15:0];
                    qin = '0;
                end
                else
                begin
                    rin = rem_reg[j-1][p];
                    lin = low_reg[j-1][p];
                    qin = quot_reg[j-1][p];
                end
                trial = {rin, lin[15]};
                ge = (trial >= {1'b0, limit});
                rem_next[j][p] = ge ? LIMIT_W'(trial - {1'b0, limit}) : LIMIT_W'(trial);
                low_next[j][p] = {lin[14:0], 1'b0};
                quot_next[j][p] = {qin[14:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        quot_reg <= quot_next;
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quot.compare_a = zero_reg[DIV_STEPS-1] ? 16'd0 : quot_reg[DIV_STEPS-1][0];
    assign quot.compare_b = zero_reg[DIV_STEPS-1] ? 16'd0 : quot_reg[DIV_STEPS-1][1];
    assign quot.compare_c = zero_reg[DIV_STEPS-1] ? 16'd0 : quot_reg[DIV_STEPS-1][2];

endmodule

>>> sim/space_vector_pwm_compare_test.sv
`timescale 1ns / 1ps

module space_vector_pwm_compare_test;

    typedef longint unsigned u64_t;

    localparam int PIPE_LATENCY = 26;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT = 8;
    localparam int ITEMS_PER_PHASE = 175;

    localparam u64_t SINE_DEPTH = 1024;
    localparam u64_t SIXTH_TURN_UNITS = 393216;
    localparam u64_t Q30_UNITY = 64'd1 << 30;
    localparam u64_t TWO_PI_Q30 = 64'd6746518852;
    localparam u64_t SQRT3_Q16 = 64'd113512;
    localparam u64_t QUARTER_TURN = 64'd16384;

    localparam logic [1:0] TAKE_NONE = 2'b00;
    localparam logic [1:0] TAKE_T1 = 2'b01;
    localparam logic [1:0] TAKE_T2 = 2'b10;
    localparam logic [1:0] TAKE_BOTH = 2'b11;

    localparam logic [svpwm_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd9;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    svpwm_pkg::cmd_t cmd = '0;
    logic done;
    svpwm_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [svpwm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic [15:0] supply_setting = svpwm_pkg::SUPPLY_VOLTAGE_RESET;
    logic [15:0] period_setting = svpwm_pkg::PWM_PERIOD_RESET;
    int sender_idle_pct = 23;
    int mismatches = 0;
    int quiet_cycles = 0;

    svpwm_pkg::cmd_t pending_cmds[$];
    svpwm_pkg::result_t expected_compares[$];

    space_vector_pwm_compare u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic u64_t sine_q16(input u64_t offset);
        u64_t idx;
        u64_t theta;
        u64_t x;
        u64_t p;
        idx = (offset * SINE_DEPTH) / SIXTH_TURN_UNITS;
        theta = (idx * TWO_PI_Q30) / SINE_DEPTH;
        x = (theta * theta) >> 30;
        p = Q30_UNITY - x / 42;
        p = Q30_UNITY - ((x * p) >> 30) / 20;
        p = Q30_UNITY - ((x * p) >> 30) / 6;
        return ((theta * p) >> 30) >> 14;
    endfunction

    function automatic longint active_time(input u64_t offset, input longint vq);
        longint gain;
        gain = longint'((SQRT3_Q16 * sine_q16(offset)) >> 16);
        return (gain * vq) / 3072;
    endfunction

    function automatic logic [15:0] phase_count(input longint doubled);
        u64_t limit;
        u64_t level;
        longint volts;
        limit = u64_t'(supply_setting) * 128;
        volts = doubled * 3;
        if (limit == 0 || volts <= 0)
            return '0;
        level = u64_t'(volts);
        if (level > limit)
            level = limit;
        return 16'((level * u64_t'(period_setting)) / limit);
    endfunction

    function automatic logic [1:0] sector_mix(input logic [2:0] sector, input int ph);
        logic [5:0] row;
        case (sector)
            3'd0: row = {TAKE_BOTH, TAKE_T2, TAKE_NONE};
            3'd1: row = {TAKE_T1, TAKE_BOTH, TAKE_NONE};
            3'd2: row = {TAKE_NONE, TAKE_BOTH, TAKE_T2};
            3'd3: row = {TAKE_NONE, TAKE_T1, TAKE_BOTH};
            3'd4: row = {TAKE_T2, TAKE_NONE, TAKE_BOTH};
            3'd5: row = {TAKE_BOTH, TAKE_NONE, TAKE_T1};
            default: row = {TAKE_NONE, TAKE_NONE, TAKE_NONE};
        endcase
        return row[5 - 2 * ph -: 2];
    endfunction

    function automatic svpwm_pkg::result_t predict_compares(input svpwm_pkg::cmd_t c);
        u64_t turn;
        u64_t sector;
        u64_t to_end;
        u64_t from_start;
        longint vq;
        longint t1;
        longint t2;
        longint t0;
        longint sum;
        logic [1:0] take;
        logic [15:0] phase_val [3];
        svpwm_pkg::result_t r;
        vq = longint'(c.voltage_q);
        turn = (u64_t'(c.electrical_angle) + QUARTER_TURN) & 64'hFFFF;
        sector = (turn * 6) >> 16;
        to_end = (sector + 1) * 65536 - 6 * turn;
        from_start = 6 * turn - sector * 65536;
        t1 = active_time(to_end, vq);
        t2 = active_time(from_start, vq);
        t0 = 65536 - t1 - t2;
        for (int ph = 0; ph < 3; ph++)
        begin
            take = sector_mix(sector[2:0], ph);
            sum = 0;
            if ((take & TAKE_T1) != 0)
                sum += t1;
            if ((take & TAKE_T2) != 0)
                sum += t2;
            phase_val[ph] = phase_count(2 * sum + t0);
        end
        r.compare_a = phase_val[0];
        r.compare_b = phase_val[1];
        r.compare_c = phase_val[2];
        return r;
    endfunction

    function automatic svpwm_pkg::cmd_t make_cmd(input int vq, input int angle);
        svpwm_pkg::cmd_t c;
        c.voltage_q = 16'(vq);
        c.electrical_angle = 16'(angle);
        return c;
    endfunction

    // Mostly realistic voltages, a quarter of the angles right at sector edges.
    function automatic svpwm_pkg::cmd_t random_cmd();
        int pick;
        int vq;
        int turn;
        pick = $urandom_range(99);
        if (pick < 55)
            vq = int'($urandom_range(6144)) - 3072;
        else if (pick < 80)
            vq = int'($urandom_range(2048)) - 1024;
        else
            vq = int'($urandom_range(65535));
        if ($urandom_range(3) == 0)
            turn = (int'($urandom_range(5)) * 65536 + 5) / 6 + int'($urandom_range(6)) - 3;
        else
            turn = int'($urandom_range(65535));
        return make_cmd(vq, turn - 16384);
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic write_register(input logic [svpwm_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == svpwm_pkg::REG_SUPPLY_VOLTAGE)
            supply_setting = value;
        else if (index == svpwm_pkg::REG_PWM_PERIOD)
            period_setting = value;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || expected_compares.size() != 0);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_compares.push_back(predict_compares(cmd));
            if (!start || !busy)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    start <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_compares.size() == 0)
            begin
                $error("result transaction with no command outstanding");
                mismatches++;
            end
            else
            begin
                svpwm_pkg::result_t want;
                want = expected_compares.pop_front();
                check_field("compare_a", want.compare_a, result.compare_a);
                check_field("compare_b", want.compare_b, result.compare_b);
                check_field("compare_c", want.compare_c, result.compare_c);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** space_vector_pwm_compare: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes of both fields, sector centers and sector edges at reset settings.
        pending_cmds.push_back(make_cmd(0, 0));
        pending_cmds.push_back(make_cmd(32767, 0));
        pending_cmds.push_back(make_cmd(-32768, 0));
        pending_cmds.push_back(make_cmd(1, 65535));
        pending_cmds.push_back(make_cmd(-1, 65535));
        pending_cmds.push_back(make_cmd(32767, 65535));
        pending_cmds.push_back(make_cmd(-32768, 32768));
        for (int j = 0; j < 6; j++)
        begin
            pending_cmds.push_back(make_cmd(1536, (2 * j + 1) * 65536 / 12 - 16384));
            pending_cmds.push_back(make_cmd(2048, (j * 65536 + 5) / 6 - 16384));
        end
        pending_cmds.push_back(make_cmd(3072, 16384));
        pending_cmds.push_back(make_cmd(-3072, 49152));
        wait_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase < 3)
                sender_idle_pct = 23;
            else if (phase < 6)
                sender_idle_pct = 74;
            else
                sender_idle_pct = 0;
            case (phase)
                0:
                begin
                    write_register(svpwm_pkg::REG_SUPPLY_VOLTAGE, 16'd3072);
                    write_register(svpwm_pkg::REG_PWM_PERIOD, 16'd4199);
                    write_register(REG_UNMAPPED, 16'($urandom));
                end
                1:
                begin
                    write_register(svpwm_pkg::REG_SUPPLY_VOLTAGE, 16'd65535);
                    write_register(svpwm_pkg::REG_PWM_PERIOD, 16'd65535);
                end
                2:
                begin
                    write_register(svpwm_pkg::REG_SUPPLY_VOLTAGE, 16'd1);
                    write_register(svpwm_pkg::REG_PWM_PERIOD, 16'd1);
                end
                3:
                begin
                    write_register(svpwm_pkg::REG_SUPPLY_VOLTAGE, 16'd0);
                    write_register(svpwm_pkg::REG_PWM_PERIOD, 16'd4199);
                end
                4:
                begin
                    write_register(svpwm_pkg::REG_SUPPLY_VOLTAGE,
                                   16'($urandom_range(1024, 8192)));
                    write_register(svpwm_pkg::REG_PWM_PERIOD, 16'($urandom_range(1, 65535)));
                end
                5:
                begin
                    write_register(svpwm_pkg::REG_SUPPLY_VOLTAGE, 16'd3072);
                    write_register(svpwm_pkg::REG_PWM_PERIOD, 16'd0);
                end
                default:
                begin
                    write_register(svpwm_pkg::REG_SUPPLY_VOLTAGE, 16'($urandom));
                    write_register(svpwm_pkg::REG_PWM_PERIOD, 16'($urandom));
                    write_register(REG_UNMAPPED, 16'($urandom));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_cmds.push_back(random_cmd());
            wait_idle();
        end

        if (mismatches == 0)
            $display("** space_vector_pwm_compare: PASSED **");
        else
            $display("** space_vector_pwm_compare: FAILED **");
        $finish;
    end

endmodule

>>> space_vector_pwm_compare.f
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_div.sv
rtl/core/space_vector_pwm_compare.sv
sim/space_vector_pwm_compare_test.sv
